// ===== hw/rtl/segi_pkg.sv =====
package segi_pkg;

   localparam int CW = 32;           // coordinate width
   localparam int FB = 16;           // fraction bits
   localparam int DW = CW + 1;       // slope / offset difference width
   localparam int NW = DW + FB;      // scaled numerator width
   localparam int PW = 2 * CW;       // product width

   localparam logic [1:0] KIND_NORMAL   = 2'd0;
   localparam logic [1:0] KIND_VERTICAL = 2'd1;

   typedef enum logic [1:0] {
      MODE_NONE,
      MODE_DIV,
      MODE_V1,
      MODE_V2
   } mode_type;

   typedef struct packed {
      mode_type             mode;
      logic signed [CW-1:0] slope;
      logic signed [CW-1:0] offset;
      logic signed [CW-1:0] xv;
      logic signed [CW-1:0] ax1;
      logic signed [CW-1:0] ay1;
      logic signed [CW-1:0] bx1;
      logic signed [CW-1:0] by1;
      logic signed [CW-1:0] ax2;
      logic signed [CW-1:0] ay2;
      logic signed [CW-1:0] bx2;
      logic signed [CW-1:0] by2;
   } ctx_type;

   typedef struct packed {
      logic          valid;
      ctx_type       ctx;
      logic          neg;
      logic          ovf;
      logic [DW-1:0] den;
      logic [NW-1:0] num;
      logic [DW-1:0] rem;
      logic [CW-1:0] quo;
   } div_type;

   // one restoring step producing quotient bit b
   function automatic div_type div_step(input div_type d, input int b);
      div_type     r;
      logic [DW:0] sh;
      r  = d;
      sh = {d.rem, d.num[b]};
      if (sh >= {1'b0, d.den}) begin
         r.rem    = DW'(sh - {1'b0, d.den});
         r.quo[b] = 1'b1;
      end else begin
         r.rem    = sh[DW-1:0];
         r.quo[b] = 1'b0;
      end
      return r;
   endfunction

endpackage

// ===== hw/rtl/segi_prep.sv =====
module segi_prep (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        enable,
   input  logic                        in_valid,
   input  logic [1:0]                  first_kind,
   input  logic signed [31:0]          first_slope,
   input  logic signed [31:0]          first_offset,
   input  logic [63:0]                 first_start_point,
   input  logic [63:0]                 first_end_point,
   input  logic [1:0]                  second_kind,
   input  logic signed [31:0]          second_slope,
   input  logic signed [31:0]          second_offset,
   input  logic [63:0]                 second_start_point,
   input  logic [63:0]                 second_end_point,
   output segi_pkg::div_type           out
);
   import segi_pkg::*;

   // stage 1: decode and differences
   logic                 v1_ff;
   ctx_type              ctx1_ff, ctx1_in;
   logic signed [DW-1:0] nd1_ff, dd1_ff;
   // stage 2: magnitudes
   logic                 v2_ff;
   ctx_type              ctx2_ff;
   logic                 neg2_ff;
   logic [DW-1:0]        na2_ff, da2_ff;
   // stage 3: overflow check and divider seed
   div_type              d3_ff, d3_in;

   logic signed [CW-1:0] s1, o1, s2, o2;
   assign s1 = first_slope[CW-1:0];
   assign o1 = first_offset[CW-1:0];
   assign s2 = second_slope[CW-1:0];
   assign o2 = second_offset[CW-1:0];

   always_comb begin
      ctx1_in.slope  = s1;
      ctx1_in.offset = o1;
      ctx1_in.xv     = o2;
      if (first_kind > KIND_VERTICAL || second_kind > KIND_VERTICAL) begin
         ctx1_in.mode = MODE_NONE;
      end else if (first_kind == KIND_VERTICAL && second_kind == KIND_VERTICAL) begin
         ctx1_in.mode = MODE_NONE;
      end else if (first_kind == KIND_NORMAL && second_kind == KIND_NORMAL && s1 == s2) begin
         ctx1_in.mode = MODE_NONE;
      end else if (first_kind == KIND_VERTICAL) begin
         ctx1_in.mode   = MODE_V1;
         ctx1_in.slope  = s2;
         ctx1_in.offset = o2;
         ctx1_in.xv     = o1;
      end else if (second_kind == KIND_VERTICAL) begin
         ctx1_in.mode = MODE_V2;
      end else begin
         ctx1_in.mode = MODE_DIV;
      end
      ctx1_in.ax1 = first_start_point[32+CW-1:32];
      ctx1_in.ay1 = first_start_point[CW-1:0];
      ctx1_in.bx1 = first_end_point[32+CW-1:32];
      ctx1_in.by1 = first_end_point[CW-1:0];
      ctx1_in.ax2 = second_start_point[32+CW-1:32];
      ctx1_in.ay2 = second_start_point[CW-1:0];
      ctx1_in.bx2 = second_end_point[32+CW-1:32];
      ctx1_in.by2 = second_end_point[CW-1:0];
   end

   always_comb begin
      d3_in       = '0;
      d3_in.valid = v2_ff;
      d3_in.ctx   = ctx2_ff;
      d3_in.neg   = neg2_ff;
      d3_in.den   = da2_ff;
      d3_in.num   = {na2_ff, {FB{1'b0}}};
      d3_in.ovf   = ({{(DW-(NW-CW)){1'b0}}, d3_in.num[NW-1:CW]} >= da2_ff);
      d3_in.rem   = {{(DW-(NW-CW)){1'b0}}, d3_in.num[NW-1:CW]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (enable) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         ctx1_ff <= ctx1_in;
         nd1_ff  <= DW'(o2) - DW'(o1);
         dd1_ff  <= DW'(s1) - DW'(s2);
         ctx2_ff <= ctx1_ff;
         neg2_ff <= nd1_ff[DW-1] ^ dd1_ff[DW-1];
         na2_ff  <= nd1_ff[DW-1] ? DW'(-nd1_ff) : nd1_ff;
         da2_ff  <= dd1_ff[DW-1] ? DW'(-dd1_ff) : dd1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d3_ff.valid <= 1'b0;
      end else if (enable) begin
         d3_ff <= d3_in;
      end
   end

   assign out = d3_ff;

endmodule

// ===== hw/rtl/segi_div.sv =====
module segi_div (
   input  logic              clock,
   input  logic              reset,
   input  logic              enable,
   input  segi_pkg::div_type in,
   output segi_pkg::div_type out
);
   import segi_pkg::*;

   // one quotient bit per stage, MSB first
   div_type st_ff [CW];
   div_type st_in [CW];

   always_comb begin
      for (int i = 0; i < CW; i++) begin
         st_in[i] = div_step((i == 0) ? in : st_ff[i-1], CW - 1 - i);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CW; i++) begin
            st_ff[i].valid <= 1'b0;
         end
      end else if (enable) begin
         for (int i = 0; i < CW; i++) begin
            st_ff[i] <= st_in[i];
         end
      end
   end

   assign out = st_ff[CW-1];

endmodule

// ===== hw/rtl/segi_ycalc.sv =====
module segi_ycalc (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        enable,
   input  segi_pkg::div_type           in,
   output logic                        out_valid,
   output segi_pkg::ctx_type           out_ctx,
   output logic signed [segi_pkg::CW-1:0] out_x,
   output logic signed [segi_pkg::CW-1:0] out_y
);
   import segi_pkg::*;

   localparam logic signed [CW-1:0] MAXV = {1'b0, {(CW-1){1'b1}}};
   localparam logic signed [CW-1:0] MINV = {1'b1, {(CW-1){1'b0}}};

   logic                 vx_ff, vm_ff, vy_ff;
   ctx_type              cx_ff, cm_ff, cy_ff;
   logic signed [CW-1:0] x_ff, x_in, xm_ff, y_ff, y_in;
   logic signed [PW-1:0] p_ff, sum;

   always_comb begin
      if (in.ctx.mode == MODE_V1 || in.ctx.mode == MODE_V2) begin
         x_in = in.ctx.xv;
      end else if (in.ovf) begin
         x_in = in.neg ? MINV : MAXV;
      end else if (!in.neg) begin
         x_in = in.quo[CW-1] ? MAXV : in.quo;
      end else begin
         x_in = (in.quo[CW-1] && |in.quo[CW-2:0]) ? MINV : CW'(-in.quo);
      end
   end

   // floor shift plus offset, then clamp
   assign sum = (p_ff >>> FB) + PW'(cm_ff.offset);

   always_comb begin
      if (sum[PW-1:CW-1] == '0 || sum[PW-1:CW-1] == '1) begin
         y_in = sum[CW-1:0];
      end else begin
         y_in = sum[PW-1] ? MINV : MAXV;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vx_ff <= 1'b0;
         vm_ff <= 1'b0;
         vy_ff <= 1'b0;
      end else if (enable) begin
         vx_ff <= in.valid;
         vm_ff <= vx_ff;
         vy_ff <= vm_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         cx_ff <= in.ctx;
         x_ff  <= x_in;
         cm_ff <= cx_ff;
         xm_ff <= x_ff;
         p_ff  <= PW'(cx_ff.slope) * PW'(x_ff);
         cy_ff <= cm_ff;
         y_ff  <= y_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         out_x <= xm_ff;
      end
   end

   assign out_valid = vy_ff;
   assign out_ctx   = cy_ff;
   assign out_y     = y_ff;

endmodule

// ===== hw/rtl/segment_intersection.sv =====
// channel | dir | handshake             | payload
// req     | in  | req_valid / req_stall | two segments: kind, slope, offset, end points
// rsp     | out | rsp_valid / rsp_stall | rsp_hit, rsp_cross_x, rsp_cross_y
//
// One beat per cycle unless a held output beat stalls the pipe; the restoring
// divider between prep and y calc yields one quotient bit per stage.
// Synchronous active-high reset clears only the stage valid bits.
// A stalled result freezes the whole pipe; req_stall follows it the same cycle.
module segment_intersection (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_first_kind,
   input  logic signed [31:0] req_first_slope,
   input  logic signed [31:0] req_first_offset,
   input  logic [63:0]        req_first_start_point,
   input  logic [63:0]        req_first_end_point,
   input  logic [1:0]         req_second_kind,
   input  logic signed [31:0] req_second_slope,
   input  logic signed [31:0] req_second_offset,
   input  logic [63:0]        req_second_start_point,
   input  logic [63:0]        req_second_end_point,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_hit,
   output logic signed [31:0] rsp_cross_x,
   output logic signed [31:0] rsp_cross_y
);
   import segi_pkg::*;

   logic                 enable;
   div_type              prep_out, div_out;
   logic                 yc_valid;
   ctx_type              yc_ctx;
   logic signed [CW-1:0] yc_x, yc_y;

   logic                 rsp_valid_ff;
   logic                 hit_ff, hit_in;
   logic signed [CW-1:0] x_ff, y_ff;

   // whole pipe advances unless the output beat is held
   assign enable    = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !enable;

   segi_prep u_prep (
      .clock              (clock),
      .reset              (reset),
      .enable             (enable),
      .in_valid           (req_valid),
      .first_kind         (req_first_kind),
      .first_slope        (req_first_slope),
      .first_offset       (req_first_offset),
      .first_start_point  (req_first_start_point),
      .first_end_point    (req_first_end_point),
      .second_kind        (req_second_kind),
      .second_slope       (req_second_slope),
      .second_offset      (req_second_offset),
      .second_start_point (req_second_start_point),
      .second_end_point   (req_second_end_point),
      .out                (prep_out)
   );

   segi_div u_div (
      .clock  (clock),
      .reset  (reset),
      .enable (enable),
      .in     (prep_out),
      .out    (div_out)
   );

   segi_ycalc u_ycalc (
      .clock     (clock),
      .reset     (reset),
      .enable    (enable),
      .in        (div_out),
      .out_valid (yc_valid),
      .out_ctx   (yc_ctx),
      .out_x     (yc_x),
      .out_y     (yc_y)
   );

   // inclusive box test against both segments
   function automatic logic in_span(input logic signed [CW-1:0] v,
                                    input logic signed [CW-1:0] a,
                                    input logic signed [CW-1:0] b);
      logic ok;
      ok = (a < b) ? (v >= a && v <= b) : (v >= b && v <= a);
      return ok;
   endfunction

   always_comb begin
      hit_in = (yc_ctx.mode != MODE_NONE)
               && in_span(yc_x, yc_ctx.ax1, yc_ctx.bx1)
               && in_span(yc_x, yc_ctx.ax2, yc_ctx.bx2)
               && in_span(yc_y, yc_ctx.ay1, yc_ctx.by1)
               && in_span(yc_y, yc_ctx.ay2, yc_ctx.by2);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (enable) begin
         rsp_valid_ff <= yc_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         hit_ff <= hit_in;
         x_ff   <= hit_in ? yc_x : '0;
         y_ff   <= hit_in ? yc_y : '0;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_hit     = hit_ff;
   assign rsp_cross_x = 32'(x_ff);
   assign rsp_cross_y = 32'(y_ff);

endmodule

// ===== tb/sv/tb_segment_intersection.sv =====
module tb_segment_intersection;
   timeunit 1ns;
   timeprecision 1ps;
   import segi_pkg::*;

   // One segment pair as driven on the request side.
   typedef struct {
      logic [1:0]         k1, k2;
      logic signed [31:0] s1, o1, s2, o2;
      logic [63:0]        a1, b1, a2, b2;
   } pair_type;

   // One intersection result as seen on the response side.
   typedef struct {
      logic               hit;
      logic signed [31:0] x, y;
   } cross_type;

   localparam logic [1:0] KIND_UNDEF  = 2'd2;
   localparam logic [1:0] KIND_UNUSED = 2'd3;
   localparam int         PIPE_DEPTH  = 3 + CW + 4;
   localparam longint     Q_MAX       = 64'sd2147483647;
   localparam longint     Q_MIN       = -64'sd2147483648;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [1:0]         req_first_kind = '0;
   logic signed [31:0] req_first_slope = '0;
   logic signed [31:0] req_first_offset = '0;
   logic [63:0]        req_first_start_point = '0;
   logic [63:0]        req_first_end_point = '0;
   logic [1:0]         req_second_kind = '0;
   logic signed [31:0] req_second_slope = '0;
   logic signed [31:0] req_second_offset = '0;
   logic [63:0]        req_second_start_point = '0;
   logic [63:0]        req_second_end_point = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b1;
   logic               rsp_hit;
   logic signed [31:0] rsp_cross_x;
   logic signed [31:0] rsp_cross_y;

   pair_type  pending_pairs[$];   // filled by the stimulus block, drained by the driver
   cross_type expected_cross[$];  // predictions waiting for their response beat
   int        errors = 0;
   bit        hold_req = 1'b0;    // pressure: sender pauses until the pipe drains

   segment_intersection dut (.*);

   always #6 clock = ~clock;

   // ------------------------------------------------------------------
   // Prediction
   // ------------------------------------------------------------------
   function automatic longint clamp_q(longint v);
      if (v > Q_MAX) return Q_MAX;
      if (v < Q_MIN) return Q_MIN;
      return v;
   endfunction

   // y on a normal line: floor(slope*x / 2^FB) + offset, clamped.
   // The 64-bit product cannot overflow for 32-bit operands.
   function automatic longint line_y_at(longint s, longint x, longint o);
      longint p;
      p = s * x;
      return clamp_q((p >>> FB) + o);
   endfunction

   function automatic bit in_box(longint v, longint a, longint b);
      if (a < b) return v >= a && v <= b;
      return v >= b && v <= a;
   endfunction

   function automatic cross_type predict_cross(pair_type p);
      cross_type r;
      longint x, y, num, den;
      bit     ok;
      r  = '{hit: 1'b0, x: '0, y: '0};
      x  = 0;
      y  = 0;
      ok = 1'b1;
      if (p.k1 > KIND_VERTICAL || p.k2 > KIND_VERTICAL) ok = 1'b0;
      else if (p.k1 == KIND_VERTICAL && p.k2 == KIND_VERTICAL) ok = 1'b0;
      else if (p.k1 == KIND_NORMAL && p.k2 == KIND_NORMAL && p.s1 == p.s2) ok = 1'b0;
      else if (p.k1 == KIND_VERTICAL) begin
         x = p.o1;
         y = line_y_at(p.s2, x, p.o2);
      end else if (p.k2 == KIND_VERTICAL) begin
         x = p.o2;
         y = line_y_at(p.s1, x, p.o1);
      end else begin
         // SV signed division truncates toward zero, as required
         num = (longint'(p.o2) - longint'(p.o1)) * (64'sd1 <<< FB);
         den = longint'(p.s1) - longint'(p.s2);
         x   = clamp_q(num / den);
         y   = line_y_at(p.s1, x, p.o1);
      end
      if (ok)
         ok = in_box(x, $signed(p.a1[63:32]), $signed(p.b1[63:32]))
           && in_box(x, $signed(p.a2[63:32]), $signed(p.b2[63:32]))
           && in_box(y, $signed(p.a1[31:0]), $signed(p.b1[31:0]))
           && in_box(y, $signed(p.a2[31:0]), $signed(p.b2[31:0]));
      if (ok) begin
         r.hit = 1'b1;
         r.x   = x[31:0];
         r.y   = y[31:0];
      end
      return r;
   endfunction

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------
   function automatic logic [31:0] rand_q();
      case ($urandom_range(0, 9))
         0: return 32'h7fff_ffff;
         1: return 32'h8000_0000;
         2: return $urandom_range(0, 1) ? 32'h0001_0000 : 32'hffff_0000;
         3, 4: return $urandom;
         default: return 32'($signed($urandom_range(0, 2 * 65536 * 64)) - 65536 * 64);
      endcase
   endfunction

   function automatic logic [1:0] rand_kind();
      case ($urandom_range(0, 15))
         0: return KIND_UNDEF;
         1: return KIND_UNUSED;
         2, 3, 4: return KIND_VERTICAL;
         default: return KIND_NORMAL;
      endcase
   endfunction

   // Random pair: bounding boxes are mostly built around the true crossing
   // (with random slack), so many of these land as hits.
   function automatic pair_type rand_pair();
      pair_type  p;
      cross_type c;
      int        sl;
      p.k1 = rand_kind();
      p.k2 = rand_kind();
      p.s1 = rand_q();
      p.s2 = $urandom_range(0, 15) == 0 ? p.s1 : rand_q();
      p.o1 = rand_q();
      p.o2 = rand_q();
      p.a1 = {$urandom, $urandom};
      p.b1 = {$urandom, $urandom};
      p.a2 = {$urandom, $urandom};
      p.b2 = {$urandom, $urandom};
      if ($urandom_range(0, 3) != 0) begin
         p.a1 = {32'h8000_0000, 32'h8000_0000};
         p.b1 = {32'h7fff_ffff, 32'h7fff_ffff};
         p.a2 = p.b1;
         p.b2 = p.a1;
         c = predict_cross(p);
         if (p.k1 <= KIND_VERTICAL && p.k2 <= KIND_VERTICAL) begin
            sl = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 4096);
            // tight box: corners at +-slack around the point, sometimes off by one
            c = predict_cross('{k1: p.k1, k2: p.k2, s1: p.s1, o1: p.o1, s2: p.s2,
               o2: p.o2, a1: p.a1, b1: p.b1, a2: p.a2, b2: p.b2});
            if (c.hit) begin
               p.a1 = {32'(c.x - sl), 32'(c.y + sl)};
               p.b1 = {32'(c.x + sl), 32'(c.y - sl)};
               if ($urandom_range(0, 7) == 0) p.b1[63:32] = 32'(c.x - 1);
               p.a2 = $urandom_range(0, 1) ? p.b1 : {32'(c.x), 32'(c.y)};
               p.b2 = {32'(c.x + $urandom_range(0, 3)), 32'(c.y - $urandom_range(0, 3))};
               if ($urandom_range(0, 7) == 0) p.a2[31:0] = 32'(c.y + 1);
               if ($urandom_range(0, 7) == 0) p.a2[31:0] = 32'(c.y - 1);
            end
         end
      end
      return p;
   endfunction

   function automatic pair_type mk(logic [1:0] k1, logic [31:0] s1, logic [31:0] o1,
                                   logic [1:0] k2, logic [31:0] s2, logic [31:0] o2);
      pair_type p;
      p = '{k1: k1, s1: s1, o1: o1, k2: k2, s2: s2, o2: o2,
            a1: {32'h8000_0000, 32'h8000_0000}, b1: {32'h7fff_ffff, 32'h7fff_ffff},
            a2: {32'h7fff_ffff, 32'h7fff_ffff}, b2: {32'h8000_0000, 32'h8000_0000}};
      return p;
   endfunction

   // ------------------------------------------------------------------
   // Driver: presents pending pairs, changes on the falling edge
   // ------------------------------------------------------------------
   int  req_gap = 0;
   bit  beat_taken;   // request accepted at the last rising edge

   always @(negedge clock) begin
      if (!reset) begin
         if (beat_taken) void'(pending_pairs.pop_front());
         if (req_valid && !beat_taken) begin
            // stalled beat holds its payload
         end else if (req_gap > 0) begin
            req_gap   <= req_gap - 1;
            req_valid <= 1'b0;
         end else if (pending_pairs.size() != 0 && !hold_req) begin
            req_valid              <= 1'b1;
            req_first_kind         <= pending_pairs[0].k1;
            req_first_slope        <= pending_pairs[0].s1;
            req_first_offset       <= pending_pairs[0].o1;
            req_first_start_point  <= pending_pairs[0].a1;
            req_first_end_point    <= pending_pairs[0].b1;
            req_second_kind        <= pending_pairs[0].k2;
            req_second_slope       <= pending_pairs[0].s2;
            req_second_offset      <= pending_pairs[0].o2;
            req_second_start_point <= pending_pairs[0].a2;
            req_second_end_point   <= pending_pairs[0].b2;
            // mostly back to back, some short gaps, a rare long one
            case ($urandom_range(0, 19))
               0, 1, 2: req_gap <= $urandom_range(1, 3);
               3: req_gap <= $urandom_range(10, 60);
               default: req_gap <= 0;
            endcase
         end else begin
            req_valid <= 1'b0;
         end
         // receiver back-pressure on its own random schedule
         case ($urandom_range(0, 39))
            0, 1, 2, 3, 4, 5: rsp_stall <= 1'b1;
            6: rsp_stall <= ($urandom_range(0, 3) != 0);
            default: rsp_stall <= 1'b0;
         endcase
      end
   end

   // Prediction happens at acceptance, sampled on the rising edge.
   always @(posedge clock) begin
      beat_taken = !reset && req_valid && !req_stall;
      if (beat_taken)
         expected_cross.push_back(predict_cross('{k1: req_first_kind, s1: req_first_slope,
            o1: req_first_offset, a1: req_first_start_point, b1: req_first_end_point,
            k2: req_second_kind, s2: req_second_slope, o2: req_second_offset,
            a2: req_second_start_point, b2: req_second_end_point}));
   end

   // ------------------------------------------------------------------
   // Monitor: compare each response beat with the oldest prediction
   // ------------------------------------------------------------------
   cross_type want;

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_cross.size() == 0) begin
            $error("response beat with no prediction pending");
            errors++;
         end else begin
            want = expected_cross.pop_front();
            if (rsp_hit !== want.hit) begin
               $error("hit: expected %0b actual %0b", want.hit, rsp_hit);
               errors++;
            end
            if (rsp_cross_x !== want.x) begin
               $error("cross_x: expected %h actual %h", want.x, rsp_cross_x);
               errors++;
            end
            if (rsp_cross_y !== want.y) begin
               $error("cross_y: expected %h actual %h", want.y, rsp_cross_y);
               errors++;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Stimulus and end of run
   // ------------------------------------------------------------------
   initial begin
      pair_type p;
      // directed: undefined / unused kinds, parallel, vertical, overflow
      pending_pairs.push_back(mk(KIND_UNDEF, 32'h1_0000, 0, KIND_NORMAL, 0, 0));
      pending_pairs.push_back(mk(KIND_NORMAL, 0, 0, KIND_UNUSED, 32'h1_0000, 0));
      pending_pairs.push_back(mk(KIND_NORMAL, 32'h2_0000, 5, KIND_NORMAL, 32'h2_0000, 9));
      pending_pairs.push_back(mk(KIND_VERTICAL, 1, 32'h3_0000, KIND_VERTICAL, 2, 0));
      pending_pairs.push_back(mk(KIND_VERTICAL, 32'hdead_beef, 32'h3_0000,
                                 KIND_NORMAL, 32'h1_8000, 32'hffff_0000));
      pending_pairs.push_back(mk(KIND_NORMAL, 32'hffff_8000, 32'h2_0000,
                                 KIND_VERTICAL, 32'h1234_5678, 32'hfffd_0000));
      pending_pairs.push_back(mk(KIND_NORMAL, 32'h1_0000, 0, KIND_NORMAL, 32'hffff_0000,
                                 32'h4_0000));
      pending_pairs.push_back(mk(KIND_NORMAL, 32'h7fff_ffff, 32'h8000_0000,
                                 KIND_NORMAL, 32'h8000_0000, 32'h7fff_ffff));
      pending_pairs.push_back(mk(KIND_NORMAL, 1, 32'h8000_0000, KIND_NORMAL, 0,
                                 32'h7fff_ffff));
      pending_pairs.push_back(mk(KIND_NORMAL, 0, 32'h7fff_ffff, KIND_NORMAL, 1,
                                 32'h8000_0000));
      pending_pairs.push_back(mk(KIND_VERTICAL, 0, 32'h7fff_ffff, KIND_NORMAL,
                                 32'h7fff_ffff, 32'h7fff_ffff));
      pending_pairs.push_back(mk(KIND_VERTICAL, 0, 32'h8000_0000, KIND_NORMAL,
                                 32'h7fff_ffff, 32'h8000_0000));
      pending_pairs.push_back(mk(KIND_NORMAL, 32'h8000_0000, 0, KIND_VERTICAL, 0,
                                 32'hffff_ffff));
      // outside bounds: tiny box that misses the crossing
      p = mk(KIND_NORMAL, 32'h1_0000, 0, KIND_NORMAL, 32'hffff_0000, 32'h4_0000);
      p.a1 = {32'h5_0000, 32'h0};
      p.b1 = {32'h6_0000, 32'h9_0000};
      pending_pairs.push_back(p);
      // exactly on the box corner, reversed corners
      p = mk(KIND_NORMAL, 32'h1_0000, 0, KIND_NORMAL, 32'hffff_0000, 32'h4_0000);
      p.a1 = {32'h2_0000, 32'h2_0000};
      p.b1 = {32'h0, 32'h0};
      p.a2 = {32'h2_0000, 32'h2_0000};
      p.b2 = {32'h2_0000, 32'h2_0000};
      pending_pairs.push_back(p);
      pending_pairs.push_back('{k1: 2'b11, k2: 2'b11, s1: '1, o1: '1, s2: '1, o2: '1,
                                a1: '1, b1: '1, a2: '1, b2: '1});
      pending_pairs.push_back('{k1: 2'b00, k2: 2'b00, s1: '0, o1: '0, s2: '0, o2: '0,
                                a1: '0, b1: '0, a2: '0, b2: '0});
      for (int i = 0; i < 900; i++) pending_pairs.push_back(rand_pair());

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // pressure: let the pipe drain completely before the second half
      wait (pending_pairs.size() == 0);
      @(negedge clock);
      hold_req = 1'b1;
      while (expected_cross.size() != 0 || req_valid) @(posedge clock);
      for (int i = 0; i < 900; i++) pending_pairs.push_back(rand_pair());
      @(negedge clock);
      hold_req = 1'b0;

      wait (pending_pairs.size() == 0);
      while (expected_cross.size() != 0) @(posedge clock);
      repeat (PIPE_DEPTH + 10) @(posedge clock);
      if (errors == 0 && expected_cross.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      #3ms;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
